// ----- design/lpht_pkg.sv -----
`default_nettype none

package lpht_pkg;

	// Table geometry (slot count is a power of two: home slot is the low key bits)
	localparam int SLOTS = 32;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Operation codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_DUPLICATE = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	// Slot marks
	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [30:0]        key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] found_value;
		logic [5:0]         entry_total;
	} rsp_t;

	// One table slot as held in the memory
	typedef struct packed {
		logic [1:0]  mark;
		logic [30:0] key;
		logic [31:0] data;
	} slot_t;

endpackage

`default_nettype wire

// ----- design/lpht_ram.sv -----
`default_nettype none

module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- design/linear_probe_hash_table_core.sv -----
`default_nettype none

// Open-addressed key/value table of SLOTS slots with linear probing and
// tombstones. Each request beat (insert, delete or lookup) gives exactly one
// response beat with a status, the value found or removed, and the live entry
// count. Requests are taken one at a time: the accept cycle reads the home
// slot, then one slot is examined per cycle while the response register is
// free or being taken, through the single read port of the slot memory, and
// an item probes 1 to SLOTS slots; the response is registered and the next
// request may be taken in the cycle after the last probe, while that response
// still waits. All slots read as empty after reset at once.
module linear_probe_hash_table_core import lpht_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	typedef enum logic {S_IDLE, S_PROBE} state_t;

	state_t             state_q;
	req_t               op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   n_q;
	logic [CNT_W-1:0]   count_q;
	logic [SLOTS-1:0]   valid_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	slot_t              rd_slot;
	slot_t              wr_slot;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   idx_nxt;
	logic [1:0]         cur_mark;
	logic               key_hit;
	logic               last;
	logic               step;
	logic               done;
	logic               rsp_load;
	logic               wr_req;
	logic               ram_we;
	logic [1:0]         status;
	logic signed [31:0] fval;
	logic [CNT_W-1:0]   cnt_nxt;

	// slot memory
	lpht_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(wr_slot),
		.raddr(raddr),
		.rdata(rd_slot)
	);

	// probe view of the slot just read
	assign cur_mark = valid_q[idx_q] ? rd_slot.mark : MARK_EMPTY;
	assign key_hit  = rd_slot.key == op_q.key;
	assign last     = n_q == IDX_W'(SLOTS - 1);
	assign idx_nxt  = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign step     = (state_q == S_PROBE) && (!rsp_valid_q || rsp_ready);
	assign ram_we   = step && wr_req;
	assign rsp_load = step && done;

	// probe decision
	always_comb begin
		done    = 1'b0;
		wr_req  = 1'b0;
		status  = STAT_NOT_FOUND;
		fval    = '0;
		wr_slot = rd_slot;
		cnt_nxt = count_q;
		if (op_q.action == ACT_INSERT) begin
			if (cur_mark != MARK_LIVE) begin
				done         = 1'b1;
				wr_req       = 1'b1;
				status       = STAT_DONE;
				wr_slot.mark = MARK_LIVE;
				wr_slot.key  = op_q.key;
				wr_slot.data = op_q.value;
				cnt_nxt      = count_q + 1'b1;
			end else if (key_hit) begin
				done   = 1'b1;
				status = STAT_DUPLICATE;
			end else if (last) begin
				done   = 1'b1;
				status = STAT_FULL;
			end
		end else begin
			if (cur_mark == MARK_EMPTY) begin
				done = 1'b1;
			end else if (cur_mark == MARK_LIVE && key_hit) begin
				done   = 1'b1;
				status = STAT_DONE;
				fval   = rd_slot.data;
				if (op_q.action == ACT_DELETE) begin
					wr_req       = 1'b1;
					wr_slot.mark = MARK_TOMB;
					if (count_q != '0) begin
						cnt_nxt = count_q - 1'b1;
					end
				end
			end else if (last) begin
				done = 1'b1;
			end
		end
	end

	// read address: home slot on accept, next slot while probing
	always_comb begin
		if (state_q == S_IDLE) begin
			raddr = req.key[IDX_W-1:0];
		end else if (step && !done) begin
			raddr = idx_nxt;
		end else begin
			raddr = idx_q;
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// sequencer, counters, valid bits and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			count_q     <= '0;
			valid_q     <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// response beat: loaded at the last probe, cleared when taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req;
						idx_q   <= req.key[IDX_W-1:0];
						n_q     <= '0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (step) begin
						if (done) begin
							if (wr_req) begin
								valid_q[idx_q] <= 1'b1;
							end
							count_q           <= cnt_nxt;
							rsp_q.status      <= status;
							rsp_q.found_value <= fval;
							rsp_q.entry_total <= 6'(cnt_nxt);
							state_q           <= S_IDLE;
						end else begin
							idx_q <= idx_nxt;
							n_q   <= n_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// live count never exceeds the slot count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("live count above slot count");

	// a slot written is marked valid from the next cycle
	a_valid_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(idx_q)])
		else $error("written slot not marked valid");

	// a successful insert adds exactly one entry
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && op_q.action == ACT_INSERT) |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not add one entry");

	// no slot write and no response load while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> !($past(ram_we)) && (rsp_valid_q == 1'b0 || $past(rsp_valid_q)))
		else $error("activity while idle");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import lpht_pkg::*;

	// Spare operation code, handled by the block as a lookup
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Random episode kinds
	localparam int EP_FILL  = 0;
	localparam int EP_MIXED = 1;
	localparam int EP_DRAIN = 2;

	localparam int EPISODES     = 15;
	localparam int EPISODE_LEN  = 60;
	localparam int POOL_SIZE    = 64;
	localparam int POOL_W       = $clog2(POOL_SIZE);
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int STUCK_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * (SLOTS + 1) + 4;
	localparam int REPORT_LINES = 40;

	typedef struct packed {
		req_t beat;
		logic fixed_want;
		rsp_t want;
	} stim_row_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow copy of the table
	logic [1:0]       shadow_mark [SLOTS];
	logic [30:0]      shadow_key  [SLOTS];
	logic [31:0]      shadow_data [SLOTS];
	logic [CNT_W-1:0] shadow_live;

	rsp_t        pending_replies[$];
	stim_row_t   directed_rows[$];
	logic [30:0] key_pool[POOL_SIZE];

	int unsigned mismatch_count = 0;
	int unsigned replies_seen   = 0;
	int unsigned stuck_cycles   = 0;
	bit          long_hold_done = 1'b0;

	linear_probe_hash_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < REPORT_LINES)
			$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Apply one operation to the shadow table and return the reply it gives.
	// SLOTS is a power of two, so the home slot is the low key bits and the
	// probe index wraps by itself.
	function automatic rsp_t shadow_apply(input req_t op);
		rsp_t             res;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] hit;
		bit               located;
		res.status      = STAT_NOT_FOUND;
		res.found_value = '0;
		idx             = op.key[IDX_W-1:0];
		hit             = '0;
		located         = 1'b0;
		if (op.action == ACT_INSERT) begin
			// first non-live slot wins; a live copy of the key stops the probe
			res.status = STAT_FULL;
			for (int n = 0; n < SLOTS; n++) begin
				if (shadow_mark[idx] != MARK_LIVE) begin
					shadow_mark[idx] = MARK_LIVE;
					shadow_key[idx]  = op.key;
					shadow_data[idx] = op.value;
					shadow_live      = shadow_live + 1'b1;
					res.status       = STAT_DONE;
					break;
				end
				if (shadow_key[idx] == op.key) begin
					res.status = STAT_DUPLICATE;
					break;
				end
				idx = idx + 1'b1;
			end
		end else begin
			// delete, lookup and the spare code: skip tombstones, stop on empty
			for (int n = 0; n < SLOTS; n++) begin
				if (shadow_mark[idx] == MARK_EMPTY)
					break;
				if (shadow_mark[idx] == MARK_LIVE && shadow_key[idx] == op.key) begin
					located = 1'b1;
					hit     = idx;
					break;
				end
				idx = idx + 1'b1;
			end
			if (located) begin
				res.status      = STAT_DONE;
				res.found_value = shadow_data[hit];
				if (op.action == ACT_DELETE) begin
					shadow_mark[hit] = MARK_TOMB;
					if (shadow_live != 0)
						shadow_live = shadow_live - 1'b1;
				end
			end
		end
		res.entry_total = shadow_live[5:0];
		return res;
	endfunction

	function automatic stim_row_t plan_row(input logic [1:0] action, input logic [30:0] key,
			input logic [31:0] value, input logic fixed_want, input logic [1:0] status,
			input logic [31:0] found_value, input logic [5:0] entry_total);
		stim_row_t r;
		r.beat.action      = action;
		r.beat.key         = key;
		r.beat.value       = value;
		r.fixed_want       = fixed_want;
		r.want.status      = status;
		r.want.found_value = found_value;
		r.want.entry_total = entry_total;
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Keys cluster on a few home slots half the time to build long probe chains
	function automatic logic [30:0] make_key();
		logic [31:0] bits;
		bits = $urandom();
		if ($urandom_range(0, 1))
			bits[IDX_W-1:0] = IDX_W'($urandom_range(0, 5));
		return bits[30:0];
	endfunction

	function automatic logic [1:0] pick_action(input int kind);
		int unsigned r;
		int unsigned ins_th;
		int unsigned del_th;
		int unsigned look_th;
		r = $urandom_range(0, 99);
		if (kind == EP_FILL) begin
			ins_th = 70; del_th = 80; look_th = 96;
		end else if (kind == EP_MIXED) begin
			ins_th = 35; del_th = 65; look_th = 95;
		end else begin
			ins_th = 15; del_th = 75; look_th = 95;
		end
		if (r < ins_th)
			return ACT_INSERT;
		if (r < del_th)
			return ACT_DELETE;
		if (r < look_th)
			return ACT_LOOKUP;
		return ACT_SPARE;
	endfunction

	// Offer one request beat and hold it until taken; entered and left at a
	// falling edge so valid is never dropped and raised in the same step
	task automatic offer_beat(input req_t beat, input logic fixed_want, input rsp_t want,
			input bit no_gaps);
		int unsigned gap;
		rsp_t        model_rsp;
		gap = no_gaps ? 0 : pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		model_rsp = shadow_apply(beat);
		pending_replies.push_back(fixed_want ? want : model_rsp);
		@(negedge clk);
	endtask

	// Reply side: random stalls, one long hold-off, check each beat in order
	initial begin : reply_side
		int unsigned stall;
		rsp_t        want;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!long_hold_done && replies_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				stall = ((replies_seen / 64) % 4 == 3) ? 0 : pick_gap();
				if (stall != 0) begin
					rsp_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			replies_seen++;
			if (pending_replies.size() == 0) begin
				flag_mismatch("reply beat with no request outstanding");
			end else begin
				want = pending_replies.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch($sformatf("status got %0d want %0d",
						rsp.status, want.status));
				if (rsp.found_value !== want.found_value)
					flag_mismatch($sformatf("found_value got %h want %h",
						rsp.found_value, want.found_value));
				if (rsp.entry_total !== want.entry_total)
					flag_mismatch($sformatf("entry_total got %0d want %0d",
						rsp.entry_total, want.entry_total));
			end
			@(negedge clk);
		end
	end

	// Watchdog: too long without a beat on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin : request_side
		req_t      beat;
		rsp_t      none;
		bit        no_gaps;
		int        kind;
		logic [31:0] bits;

		none = '0;
		for (int s = 0; s < SLOTS; s++)
			shadow_mark[IDX_W'(s)] = MARK_EMPTY;
		shadow_live = '0;
		for (int p = 0; p < POOL_SIZE; p++)
			key_pool[POOL_W'(p)] = make_key();

		// Directed rows: fixed replies where they are obvious, else the shadow table
		directed_rows.push_back(plan_row(ACT_LOOKUP, 31'd0, 32'd0, 1'b1,
			STAT_NOT_FOUND, 32'd0, 6'd0));
		directed_rows.push_back(plan_row(ACT_DELETE, 31'h7FFF_FFFF, 32'd0, 1'b1,
			STAT_NOT_FOUND, 32'd0, 6'd0));
		directed_rows.push_back(plan_row(ACT_SPARE, 31'd5, 32'd0, 1'b1,
			STAT_NOT_FOUND, 32'd0, 6'd0));
		directed_rows.push_back(plan_row(ACT_INSERT, 31'd0, 32'h8000_0000, 1'b1,
			STAT_DONE, 32'd0, 6'd1));
		directed_rows.push_back(plan_row(ACT_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
			STAT_DONE, 32'd0, 6'd2));
		directed_rows.push_back(plan_row(ACT_INSERT, 31'd0, 32'd5, 1'b1,
			STAT_DUPLICATE, 32'd0, 6'd2));
		directed_rows.push_back(plan_row(ACT_LOOKUP, 31'd0, 32'd0, 1'b1,
			STAT_DONE, 32'h8000_0000, 6'd2));
		directed_rows.push_back(plan_row(ACT_SPARE, 31'h7FFF_FFFF, 32'd0, 1'b1,
			STAT_DONE, 32'h7FFF_FFFF, 6'd2));
		// collision on slot 0, then a chain that wraps from the last slot
		directed_rows.push_back(plan_row(ACT_INSERT, 31'd32, 32'd77, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_INSERT, 31'd63, 32'hFFFF_FFFF, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_DELETE, 31'd0, 32'd0, 1'b1,
			STAT_DONE, 32'h8000_0000, 6'd3));
		directed_rows.push_back(plan_row(ACT_DELETE, 31'd0, 32'd0, 1'b1,
			STAT_NOT_FOUND, 32'd0, 6'd3));
		// probe past a tombstone, then reuse it and hide the older copy
		directed_rows.push_back(plan_row(ACT_LOOKUP, 31'd32, 32'd0, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_INSERT, 31'd32, 32'd1, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_LOOKUP, 31'd32, 32'd0, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_DELETE, 31'd32, 32'd0, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_LOOKUP, 31'd32, 32'd0, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_LOOKUP, 31'd64, 32'd0, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_INSERT, 31'h5555_5555, 32'h5555_5555,
			1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_INSERT, 31'h2AAA_AAAA, 32'hAAAA_AAAA,
			1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_LOOKUP, 31'h2AAA_AAAA, 32'd0, 1'b0, 0, 0, 0));
		directed_rows.push_back(plan_row(ACT_DELETE, 31'h7FFF_FFFF, 32'd0, 1'b0, 0, 0, 0));

		// Reset
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			offer_beat(directed_rows[i].beat, directed_rows[i].fixed_want,
				directed_rows[i].want, 1'b0);

		// Random episodes: fill, mix and drain over a slowly changing key pool
		for (int ep = 0; ep < EPISODES; ep++) begin
			kind    = ep % 3;
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 16; k++)
				key_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))] = make_key();
			for (int n = 0; n < EPISODE_LEN; n++) begin
				beat.action = pick_action(kind);
				if ($urandom_range(0, 99) < 85) begin
					beat.key = key_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
				end else begin
					bits     = $urandom();
					beat.key = bits[30:0];
				end
				beat.value = $urandom();
				offer_beat(beat, 1'b0, none, no_gaps);
			end
		end
		req_valid <= 1'b0;

		// Drain outstanding replies, then watch for strays
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
